// ===== rtl/core/fcv_pkg.sv =====
// Package with the shared types and constants of the frame checksum validator.
package fcv_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;

  // Frame parsing phases, in the order in which the bytes of a frame arrive.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_TYPE   = 3'd2,
    PH_SUBID  = 3'd3,
    PH_LENLO  = 3'd4,
    PH_LENHI  = 3'd5,
    PH_BODY   = 3'd6,
    PH_CHECK2 = 3'd7
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             frame_start;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] message_type;
    logic             checksum_ok;
  } result_t;

endpackage

// ===== rtl/core/fcv_ifs.sv =====
// Valid/ready channel interfaces for the byte input and the result output.
interface fcv_in_if;
  logic                     valid;
  logic                     ready;
  logic [fcv_pkg::ByteW-1:0] data_byte;
  logic                     frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface fcv_out_if;
  logic                     valid;
  logic                     ready;
  logic [fcv_pkg::ByteW-1:0] message_type;
  logic                     checksum_ok;

  modport source (output valid, output message_type, output checksum_ok, input ready);
  modport sink   (input valid, input message_type, input checksum_ok, output ready);
endinterface

// ===== rtl/core/fcv_in_stage.sv =====
// Input register stage that captures one received byte transaction.
module fcv_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  fcv_in_if.sink         in_i,
  input  logic           advance_i,
  output logic           valid_o,
  output fcv_pkg::item_t item_o
);
  import fcv_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  // The stage refills in the same cycle as its content moves on.
  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.data_byte   <= in_i.data_byte;
      item_q.frame_start <= in_i.frame_start;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/fcv_parser.sv =====
// Frame parser holding the phase, length count, type byte and running sums.
module fcv_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  fcv_pkg::item_t   item_i,
  output logic             res_valid_o,
  output fcv_pkg::result_t result_o
);
  import fcv_pkg::*;

  phase_e            phase_q, phase_d;
  logic [LenW-1:0]   remaining_q, remaining_d;
  logic [ByteW-1:0]  len_lo_q, len_lo_d;
  logic [ByteW-1:0]  type_q, type_d;
  logic [ByteW-1:0]  sum_a_q, sum_a_d;
  logic [ByteW-1:0]  sum_b_q, sum_b_d;
  logic              match1_q, match1_d;
  logic [ByteW-1:0]  sum_a_add;
  logic              body_done;
  logic              ok;

  assign sum_a_add = sum_a_q + item_i.data_byte;
  assign body_done = (remaining_q == '0);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (item_i.frame_start) begin
      phase_d = PH_SYNC2;
    end else begin
      case (phase_q)
        PH_IDLE:   phase_d = PH_IDLE;
        PH_SYNC2:  phase_d = PH_TYPE;
        PH_TYPE:   phase_d = PH_SUBID;
        PH_SUBID:  phase_d = PH_LENLO;
        PH_LENLO:  phase_d = PH_LENHI;
        PH_LENHI:  phase_d = PH_BODY;
        PH_BODY:   phase_d = body_done ? PH_CHECK2 : PH_BODY;
        PH_CHECK2: phase_d = PH_IDLE;
        default:   phase_d = PH_IDLE;
      endcase
    end
  end

  // Data registers and the result.
  always_comb begin
    remaining_d = remaining_q;
    len_lo_d    = len_lo_q;
    type_d      = type_q;
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    match1_d    = match1_q;
    res_valid_o = 1'b0;
    ok          = match1_q && (item_i.data_byte == sum_b_q);
    result_o.message_type = ok ? type_q : '0;
    result_o.checksum_ok  = ok;
    if (item_i.frame_start) begin
      remaining_d = '0;
      len_lo_d    = '0;
      type_d      = '0;
      sum_a_d     = '0;
      sum_b_d     = '0;
      match1_d    = 1'b0;
    end else begin
      case (phase_q)
        PH_TYPE:  type_d   = item_i.data_byte;
        PH_LENLO: len_lo_d = item_i.data_byte;
        PH_LENHI: remaining_d = {item_i.data_byte, len_lo_q};
        PH_BODY: begin
          if (!body_done) begin
            sum_a_d     = sum_a_add;
            sum_b_d     = sum_b_q + sum_a_add;
            remaining_d = remaining_q - 1'b1;
          end else begin
            match1_d = (item_i.data_byte == sum_a_q);
          end
        end
        PH_CHECK2: res_valid_o = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      remaining_q <= '0;
      len_lo_q    <= '0;
      type_q      <= '0;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      match1_q    <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      len_lo_q    <= len_lo_d;
      type_q      <= type_d;
      sum_a_q     <= sum_a_d;
      sum_b_q     <= sum_b_d;
      match1_q    <= match1_d;
    end
  end

endmodule

// ===== rtl/core/fcv_out_stage.sv =====
// Result register that holds a finished result until it is taken.
module fcv_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  fcv_pkg::result_t result_i,
  output logic             free_o,
  fcv_out_if.source        out_o
);
  import fcv_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.message_type = res_q.message_type;
  assign out_o.checksum_ok  = res_q.checksum_ok;

endmodule

// ===== rtl/core/frame_checksum_validator_unit.sv =====
// Top level of the frame checksum validator.
//
//   channel  dir  handshake      payload
//   in_i     in   valid / ready  data_byte[7:0], frame_start
//   out_o    out  valid / ready  message_type[7:0], checksum_ok
//
// One byte transaction is accepted in every cycle while the result side keeps up.
// After its second check byte is accepted, that byte waits in the input register and
// the result it produces then waits in the result register, from which it leaves.
// Reset clears the parse state to idle and empties both registers.
// A stall on out_o holds only a byte that would produce a result; other bytes
// keep flowing past a waiting result.
module frame_checksum_validator_unit (
  input  logic    clk_i,
  input  logic    rst_ni,
  fcv_in_if.sink  in_i,
  fcv_out_if.source out_o
);
  import fcv_pkg::*;

  logic    stage_valid;
  item_t   stage_item;
  logic    res_want;
  result_t res;
  logic    out_free;
  logic    advance;

  // The byte in the input register moves on unless it ends a frame and the
  // result register is still occupied.
  assign advance = stage_valid && (!res_want || out_free);

  fcv_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  fcv_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (stage_item),
    .res_valid_o (res_want),
    .result_o    (res)
  );

  fcv_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && res_want),
    .result_i (res),
    .free_o   (out_free),
    .out_o    (out_o)
  );

`ifndef SYNTH
  // Back-pressure on the input only ever comes from a full input register.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_valid |-> in_i.ready)
    else $error("input stalled while input register empty");

  // A result that is produced appears at the output in the next cycle.
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_want) |=> out_o.valid)
    else $error("produced result not presented");

  // A failed check always reports type zero.
  a_fail_type_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.checksum_ok) |-> (out_o.message_type == '0))
    else $error("failed check with non-zero type");

  // A held result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !(advance && res_want))
    else $error("result overwritten while stalled");
`endif

endmodule

// ===== test/fcv_checksum_monitor.sv =====
// Checker that predicts the frame checksum results and compares them with the block's output.
`timescale 1ns / 1ps

module fcv_checksum_monitor (
  input  logic clk_i,
  input  logic rst_ni,
  fcv_in_if    in_i,
  fcv_out_if   out_i,
  output int   err_count_o,
  output int   pending_o,
  output int   results_o,
  output int   ok_count_o
);
  import fcv_pkg::*;

  // Own copy of the frame parser state.
  phase_e           ph;
  logic [LenW-1:0]  remaining;
  logic [ByteW-1:0] len_lo;
  logic [ByteW-1:0] type_q;
  logic [ByteW-1:0] sum_a;
  logic [ByteW-1:0] sum_b;
  logic             check1_ok;

  result_t expected_results [$];

  // Advances the parser by one byte; returns 1 when the byte completes a frame.
  function automatic bit parse_frame_byte(input logic [ByteW-1:0] b, input logic s,
                                          output result_t res);
    bit ok;
    res = '0;
    if (s) begin
      ph        = PH_SYNC2;
      remaining = '0;
      len_lo    = '0;
      type_q    = '0;
      sum_a     = '0;
      sum_b     = '0;
      check1_ok = 1'b0;
      return 1'b0;
    end
    case (ph)
      PH_SYNC2: ph = PH_TYPE;
      PH_TYPE: begin
        type_q = b;
        ph     = PH_SUBID;
      end
      PH_SUBID: ph = PH_LENLO;
      PH_LENLO: begin
        len_lo = b;
        ph     = PH_LENHI;
      end
      PH_LENHI: begin
        remaining = {b, len_lo};
        ph        = PH_BODY;
      end
      PH_BODY: begin
        if (remaining != '0) begin
          sum_a     = sum_a + b;
          sum_b     = sum_b + sum_a;
          remaining = remaining - 1'b1;
        end else begin
          check1_ok = (b == sum_a);
          ph        = PH_CHECK2;
        end
      end
      PH_CHECK2: begin
        ok               = check1_ok && (b == sum_b);
        res.message_type = ok ? type_q : '0;
        res.checksum_ok  = ok;
        ph               = PH_IDLE;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t res;
    result_t want;
    if (!rst_ni) begin
      ph          = PH_IDLE;
      remaining   = '0;
      len_lo      = '0;
      type_q      = '0;
      sum_a       = '0;
      sum_b       = '0;
      check1_ok   = 1'b0;
      expected_results.delete();
      err_count_o = 0;
      pending_o   = 0;
      results_o   = 0;
      ok_count_o  = 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        if (parse_frame_byte(in_i.data_byte, in_i.frame_start, res)) begin
          expected_results.push_back(res);
        end
      end
      if (out_i.valid && out_i.ready) begin
        results_o++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: message_type %0h, checksum_ok %0b",
                 out_i.message_type, out_i.checksum_ok);
          err_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (want.checksum_ok) ok_count_o++;
          if (out_i.message_type !== want.message_type) begin
            $error("message_type: expected %0h, actual %0h",
                   want.message_type, out_i.message_type);
            err_count_o++;
          end
          if (out_i.checksum_ok !== want.checksum_ok) begin
            $error("checksum_ok: expected %0b, actual %0b",
                   want.checksum_ok, out_i.checksum_ok);
            err_count_o++;
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench top: byte stimulus, result back-pressure, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
  import fcv_pkg::*;

  // A run is ended when no transaction crosses either channel for this many cycles.
  // Honest quiet stretches are short: random gaps and stalls of 77 in a hundred die out soon.
  localparam int unsigned QuietLimit = 5000;
  // Bytes sent inside frames in each of the four idling phases.
  localparam int unsigned PhaseBytes = 500;

  logic clk_i;
  logic rst_ni;

  fcv_in_if  byte_if ();
  fcv_out_if result_if ();

  int          err_count;
  int          pending;
  int          results;
  int          ok_results;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned bytes_sent;
  int unsigned restarts;
  int unsigned quiet_cycles;

  frame_checksum_validator_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (result_if)
  );

  fcv_checksum_monitor i_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (byte_if),
    .out_i       (result_if),
    .err_count_o (err_count),
    .pending_o   (pending),
    .results_o   (results),
    .ok_count_o  (ok_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The result side stalls at random with the percentage set by the current phase.
  always @(posedge clk_i) begin
    result_if.ready <= rst_ni ? ($urandom_range(99) >= stall_pct) : 1'b0;
  end

  // The watchdog counts cycles in which neither channel completes a transaction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((byte_if.valid && byte_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Timeout: no transaction for %0d cycles, %0d results still awaited",
               QuietLimit, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one byte and holds it until the block takes it. Ready is looked at on the
  // falling edge, where it is settled, and the transaction completes on the next rising
  // edge. A random number of empty cycles may come first, as the phase demands.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic s);
    while ($urandom_range(99) < idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid       <= 1'b1;
    byte_if.data_byte   <= b;
    byte_if.frame_start <= s;
    @(negedge clk_i);
    while (!byte_if.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Sends a frame with a random header and payload. The check bytes are the true sums
  // unless spoil asks for the first and/or the second to be corrupted. A non-zero cut
  // sends only that many bytes, so that the next frame start lands mid-frame.
  task automatic send_frame(input logic [ByteW-1:0] msg_type, input logic [LenW-1:0] plen,
                            input int unsigned cut, input logic [1:0] spoil);
    logic [ByteW-1:0] frame_q [$];
    logic [ByteW-1:0] sa;
    logic [ByteW-1:0] sb;
    logic [ByteW-1:0] pb;
    int unsigned      i;
    int unsigned      n;
    sa = '0;
    sb = '0;
    frame_q.push_back(8'($urandom));
    frame_q.push_back(8'($urandom));
    frame_q.push_back(msg_type);
    frame_q.push_back(8'($urandom));
    frame_q.push_back(plen[7:0]);
    frame_q.push_back(plen[15:8]);
    // A cut frame never needs the rest of a long payload, so it is not built.
    for (i = 0; i < plen && (cut == 0 || frame_q.size() < cut); i++) begin
      pb = 8'($urandom);
      sa = sa + pb;
      sb = sb + sa;
      frame_q.push_back(pb);
    end
    frame_q.push_back(spoil[0] ? sa ^ 8'($urandom_range(255, 1)) : sa);
    frame_q.push_back(spoil[1] ? sb ^ 8'($urandom_range(255, 1)) : sb);
    n = (cut != 0 && cut < frame_q.size()) ? cut : frame_q.size();
    if (n < frame_q.size()) restarts++;
    for (i = 0; i < n; i++) begin
      send_byte(frame_q[i], i == 0);
      bytes_sent++;
    end
  endtask

  initial begin
    int unsigned phase_n;
    int unsigned phase_base;
    int unsigned pick;
    int unsigned plen;
    int unsigned total;
    logic [1:0]  spoil;
    rst_ni              <= 1'b0;
    byte_if.valid       <= 1'b0;
    byte_if.data_byte   <= '0;
    byte_if.frame_start <= 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    bytes_sent = 0;
    restarts   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Bytes outside any frame must be ignored without a result.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // A zero-length payload, checked against sums of zero, with the largest type value.
    send_frame(8'hFF, 16'd0, 0, 2'b00);
    // A frame broken off after four bytes is dropped silently by the next frame start.
    send_frame(8'h5A, 16'd3, 4, 2'b00);
    // A one-byte payload with a corrupted first check byte reports type zero and a fail.
    send_frame(8'h81, 16'd1, 0, 2'b01);

    // Random part in four phases of idling: none, sender gaps, result stalls, and both.
    for (phase_n = 0; phase_n < 4; phase_n++) begin
      case (phase_n)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 77; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      phase_base = bytes_sent;
      while (bytes_sent - phase_base < PhaseBytes) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // Complete frame; most payloads are short, a few run to a few hundred bytes.
          plen  = ($urandom_range(9) == 0) ? $urandom_range(300, 13) : $urandom_range(12);
          spoil = ($urandom_range(3) == 0) ? 2'($urandom_range(3, 1)) : 2'b00;
          send_frame(8'($urandom), 16'(plen), 0, spoil);
        end else if (pick < 88) begin
          // Frame broken off in any phase, up to the second check byte. Half of these
          // carry a full 16-bit length so that every bit of the high length byte moves.
          plen  = $urandom_range(1) ? $urandom_range(65535) : $urandom_range(12);
          total = 8 + plen;
          send_frame(8'($urandom), 16'(plen), $urandom_range(total - 1 < 26 ? total - 1 : 26, 1),
                     2'b00);
        end else begin
          // A short burst of stray bytes, ignored when they fall between frames.
          repeat ($urandom_range(4, 1)) send_byte(8'($urandom), 1'b0);
        end
      end
    end

    byte_if.valid <= 1'b0;
    // Wait for every outstanding result, then keep watching the output to catch strays.
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Summary: %0d frame bytes sent, %0d results checked, %0d with matching sums,",
             bytes_sent, results, ok_results);
    $display("  %0d frames restarted mid-way, over four phases of sender and receiver idling.",
             restarts);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== frame_checksum_validator_unit.f =====
rtl/core/fcv_pkg.sv
rtl/core/fcv_ifs.sv
rtl/core/fcv_in_stage.sv
rtl/core/fcv_parser.sv
rtl/core/fcv_out_stage.sv
rtl/core/frame_checksum_validator_unit.sv
test/fcv_checksum_monitor.sv
test/tb.sv
